// ===== rtl/core/prc_pkg.sv =====
// Types, constants and the control program of the pitch-rate PI controller.
package prc_pkg;

   localparam int RATE_W        = 16;
   localparam int SCALER_W      = 14;
   localparam int DT_W          = 16;
   localparam int DT_FRAC       = 16;
   localparam int GAIN_W        = 16;
   localparam int INTEG_W       = 18;
   localparam int RAW_W         = 24;
   localparam int ACT_W         = 14;
   localparam int CSR_IDX_W     = 2;
   localparam int STEP_W        = 4;
   localparam int FRAC_BITS_DEF = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P   = 2'd0,
      CSR_GAIN_I   = 2'd1,
      CSR_GAIN_FF  = 2'd2,
      CSR_INT_LIM  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate_setpoint;
      logic signed [RATE_W-1:0] measured_rate;
      logic [SCALER_W-1:0]      airspeed_scaler;
      logic [DT_W-1:0]          time_step;
      logic                     lock_integ;
      logic                     inputs_valid;
   } req_payload_type;

   typedef struct packed {
      logic signed [ACT_W-1:0] actuator;
      logic                    saturated;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      A_SCALER,
      A_SETPOINT,
      A_ERROR,
      A_TMP
   } a_sel_type;

   typedef enum logic [2:0] {
      B_SCALER,
      B_DT,
      B_S2,
      B_GAIN_P,
      B_GAIN_I,
      B_GAIN_FF
   } b_sel_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_F,
      SH_2F,
      SH_DT
   } shift_type;

   typedef enum logic [3:0] {
      D_NONE,
      D_S2,
      D_TMP,
      D_TMP_AW,
      D_ACC_LOAD,
      D_ACC_ADD,
      D_INTEG,
      D_RAW,
      D_OUT
   } dst_type;

   typedef enum logic [1:0] {
      C_NEVER,
      C_INVALID,
      C_NOINTEG
   } cond_type;

   typedef struct packed {
      cond_type          cond;
      logic [STEP_W-1:0] target;
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      shift_type         shift;
      dst_type           dst;
   } ctrl_word_type;

   localparam logic [STEP_W-1:0] STEP_INTEG_END = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd10;

   function automatic ctrl_word_type prc_rom(logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{C_NEVER, '0, A_TMP, B_S2, SH_NONE, D_NONE};
      case (step)
         4'd0: w = '{C_INVALID, STEP_EMIT, A_SCALER, B_SCALER, SH_F, D_S2};
         4'd1: w = '{C_NEVER, '0, A_SETPOINT, B_SCALER, SH_NONE, D_TMP};
         4'd2: w = '{C_NEVER, '0, A_TMP, B_GAIN_FF, SH_2F, D_ACC_LOAD};
         4'd3: w = '{C_NEVER, '0, A_ERROR, B_S2, SH_NONE, D_TMP};
         4'd4: w = '{C_NOINTEG, STEP_INTEG_END, A_TMP, B_GAIN_P, SH_2F, D_ACC_ADD};
         4'd5: w = '{C_NEVER, '0, A_ERROR, B_DT, SH_DT, D_TMP};
         4'd6: w = '{C_NEVER, '0, A_TMP, B_S2, SH_F, D_TMP_AW};
         4'd7: w = '{C_NEVER, '0, A_TMP, B_GAIN_I, SH_F, D_TMP};
         4'd8: w = '{C_NEVER, '0, A_TMP, B_S2, SH_NONE, D_INTEG};
         4'd9: w = '{C_NEVER, '0, A_TMP, B_S2, SH_NONE, D_RAW};
         default: w = '{C_NEVER, '0, A_TMP, B_S2, SH_NONE, D_OUT};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/pitch_rate_pi_controller_top.sv =====
// Pitch-rate PI controller: microcoded sequencer around one shared multiplier.
//
//  Channel | Ports                                | Direction | Moves
//  req     | req_valid, req_stall, req_payload    | in        | one sample per transfer
//  rsp     | rsp_valid, rsp_stall, rsp_payload    | out       | one command per transfer
//  csr     | csr_we, csr_index, csr_wdata         | in        | one register write
//
// One program step runs per cycle through the shared multiplier unless the final step holds.
// A valid sample runs the steps in order but skips the integrator ones when the integrator is
// locked or its gain is zero; an invalid one skips to the final step, which frees the input.
// Reset clears gains, integrator and last output, and empties the result register.
// A new sample is taken while a result waits; the final step holds while that result stalls.
module pitch_rate_pi_controller_top #(
   parameter int FRAC_BITS = prc_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  prc_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output prc_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_we,
   input  logic [prc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [prc_pkg::GAIN_W-1:0]         csr_wdata
);
   import prc_pkg::*;

   localparam int E_W    = RATE_W + 1;
   localparam int S2_W   = 2 * SCALER_W - FRAC_BITS;
   localparam int BW     = (S2_W > GAIN_W) ? S2_W : GAIN_W;
   localparam int TMP_W  = E_W + BW;
   localparam int PW     = TMP_W + BW + 1;
   localparam int ACC_A  = PW - 2 * FRAC_BITS + 2;
   localparam int ACC_W  = (ACC_A > RAW_W + 2) ? ACC_A : RAW_W + 2;
   localparam logic signed [RAW_W-1:0] ONE_Q  = RAW_W'(1 << FRAC_BITS);
   localparam logic signed [RAW_W-1:0] RAW_HI = {1'b0, {(RAW_W-1){1'b1}}};
   localparam logic signed [RAW_W-1:0] RAW_LO = {1'b1, {(RAW_W-1){1'b0}}};

   logic [GAIN_W-1:0]         gain_p_ff, gain_p_in;
   logic [GAIN_W-1:0]         gain_i_ff, gain_i_in;
   logic [GAIN_W-1:0]         gain_ff_ff, gain_ff_in;
   logic [GAIN_W-1:0]         limit_ff, limit_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [RAW_W-1:0]   raw_ff, raw_in;
   logic                      busy_ff, busy_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;
   logic signed [RATE_W-1:0]  sp_ff, sp_in;
   logic signed [E_W-1:0]     e_ff, e_in;
   logic [SCALER_W-1:0]       s_ff, s_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic                      lock_ff, lock_in;
   logic                      valid_ff, valid_in;
   logic [S2_W-1:0]           s2_ff, s2_in;
   logic signed [TMP_W-1:0]   tmp_ff, tmp_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   ctrl_word_type             cw;
   logic signed [TMP_W-1:0]   a_val;
   logic [BW-1:0]             b_val;
   logic signed [PW-1:0]      prod;
   logic signed [PW-1:0]      sh;
   logic signed [TMP_W-1:0]   sh_tmp;
   logic signed [TMP_W:0]     isum;
   logic signed [TMP_W:0]     lim_pos;
   logic signed [ACC_W:0]     rsum;
   logic                      jump;
   logic                      out_free;
   logic                      req_take;

   assign req_stall   = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign req_take    = req_valid && !busy_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign cw          = prc_rom(step_ff);

   always_comb begin
      case (cw.a_sel)
         A_SCALER:   a_val = TMP_W'($signed({1'b0, s_ff}));
         A_SETPOINT: a_val = TMP_W'(sp_ff);
         A_ERROR:    a_val = TMP_W'(e_ff);
         A_TMP:      a_val = tmp_ff;
         default:    a_val = tmp_ff;
      endcase
      case (cw.b_sel)
         B_SCALER:  b_val = BW'(s_ff);
         B_DT:      b_val = BW'(dt_ff);
         B_S2:      b_val = BW'(s2_ff);
         B_GAIN_P:  b_val = BW'(gain_p_ff);
         B_GAIN_I:  b_val = BW'(gain_i_ff);
         B_GAIN_FF: b_val = BW'(gain_ff_ff);
         default:   b_val = BW'(s2_ff);
      endcase
      prod = PW'(a_val) * PW'($signed({1'b0, b_val}));
      case (cw.shift)
         SH_NONE: sh = prod;
         SH_F:    sh = prod >>> FRAC_BITS;
         SH_2F:   sh = prod >>> (2 * FRAC_BITS);
         SH_DT:   sh = prod >>> DT_FRAC;
         default: sh = prod;
      endcase
      sh_tmp  = TMP_W'(sh);
      isum    = (TMP_W+1)'(tmp_ff) + (TMP_W+1)'(integ_ff);
      lim_pos = $signed({{(TMP_W+1-GAIN_W){1'b0}}, limit_ff});
      rsum    = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(integ_ff);
      case (cw.cond)
         C_NEVER:   jump = 1'b0;
         C_INVALID: jump = !valid_ff;
         C_NOINTEG: jump = lock_ff || (gain_i_ff == '0);
         default:   jump = 1'b0;
      endcase
   end

   always_comb begin
      gain_p_in      = gain_p_ff;
      gain_i_in      = gain_i_ff;
      gain_ff_in     = gain_ff_ff;
      limit_in       = limit_ff;
      integ_in       = integ_ff;
      raw_in         = raw_ff;
      busy_in        = busy_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      sp_in          = sp_ff;
      e_in           = e_ff;
      s_in           = s_ff;
      dt_in          = dt_ff;
      lock_in        = lock_ff;
      valid_in       = valid_ff;
      s2_in          = s2_ff;
      tmp_in         = tmp_ff;
      acc_in         = acc_ff;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:  gain_p_in  = csr_wdata;
            CSR_GAIN_I:  gain_i_in  = csr_wdata;
            CSR_GAIN_FF: gain_ff_in = csr_wdata;
            CSR_INT_LIM: limit_in   = csr_wdata;
            default:     gain_p_in  = gain_p_ff;
         endcase
      end

      if (req_take) begin
         busy_in  = 1'b1;
         step_in  = '0;
         sp_in    = req_payload.rate_setpoint;
         e_in     = E_W'(req_payload.rate_setpoint) - E_W'(req_payload.measured_rate);
         s_in     = req_payload.airspeed_scaler;
         dt_in    = req_payload.time_step;
         lock_in  = req_payload.lock_integ;
         valid_in = req_payload.inputs_valid;
      end else if (busy_ff) begin
         case (cw.dst)
            D_NONE:     acc_in = acc_ff;
            D_S2:       s2_in  = S2_W'(sh);
            D_TMP:      tmp_in = sh_tmp;
            D_TMP_AW: begin
               if ((raw_ff < -ONE_Q && sh_tmp < 0) || (raw_ff > ONE_Q && sh_tmp > 0)) begin
                  tmp_in = '0;
               end else begin
                  tmp_in = sh_tmp;
               end
            end
            D_ACC_LOAD: acc_in = ACC_W'(sh);
            D_ACC_ADD:  acc_in = acc_ff + ACC_W'(sh);
            D_INTEG: begin
               if (isum > lim_pos) begin
                  integ_in = INTEG_W'(lim_pos);
               end else if (isum < -lim_pos) begin
                  integ_in = INTEG_W'(-lim_pos);
               end else begin
                  integ_in = INTEG_W'(isum);
               end
            end
            D_RAW: begin
               if (rsum > (ACC_W+1)'(RAW_HI)) begin
                  raw_in = RAW_HI;
               end else if (rsum < (ACC_W+1)'(RAW_LO)) begin
                  raw_in = RAW_LO;
               end else begin
                  raw_in = RAW_W'(rsum);
               end
            end
            D_OUT: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (raw_ff > ONE_Q) begin
                     rsp_payload_in.actuator = ACT_W'(ONE_Q);
                  end else if (raw_ff < -ONE_Q) begin
                     rsp_payload_in.actuator = ACT_W'(-ONE_Q);
                  end else begin
                     rsp_payload_in.actuator = ACT_W'(raw_ff);
                  end
                  rsp_payload_in.saturated = (raw_ff > ONE_Q) || (raw_ff < -ONE_Q);
                  busy_in = 1'b0;
                  step_in = '0;
               end
            end
            default:    acc_in = acc_ff;
         endcase
         if (cw.dst != D_OUT) begin
            step_in = jump ? cw.target : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_ff_ff   <= '0;
         limit_ff     <= '0;
         integ_ff     <= '0;
         raw_ff       <= '0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_ff_ff   <= gain_ff_in;
         limit_ff     <= limit_in;
         integ_ff     <= integ_in;
         raw_ff       <= raw_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      sp_ff          <= sp_in;
      e_ff           <= e_in;
      s_ff           <= s_in;
      dt_ff          <= dt_in;
      lock_ff        <= lock_in;
      valid_ff       <= valid_in;
      s2_ff          <= s2_in;
      tmp_ff         <= tmp_in;
      acc_ff         <= acc_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy_ff) && !busy_ff)
      else $error("Result appeared without the program reaching its final step.");

   a_accept_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (busy_ff && step_ff == '0))
      else $error("Accepted sample did not start the program at its first step.");

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> step_ff == '0)
      else $error("Step counter left nonzero while idle.");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pitch-rate PI controller: directed table, random bursts, predictor.
module testbench;
   import prc_pkg::*;

   localparam int     FRAC           = FRAC_BITS_DEF;
   localparam longint RAW_HI         = (longint'(1) <<< (RAW_W - 1)) - 1;
   localparam longint RAW_LO         = -(longint'(1) <<< (RAW_W - 1));
   localparam int     NUM_PHASES     = 8;
   localparam int     PHASE_ITEMS    = 125;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     DRAIN_CYCLES   = 40;

   localparam logic [GAIN_W-1:0] GAIN_SETS [6][4] = '{
      '{16'hffff, 16'hffff, 16'hffff, 16'hffff},
      '{16'h1000, 16'h0800, 16'h1000, 16'h1000},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h2000, 16'h0000, 16'h1800, 16'hffff},
      '{16'h0400, 16'h4000, 16'h0000, 16'h0200},
      '{16'h0c00, 16'h0300, 16'h0800, 16'h0600}
   };

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_CHECKED,
      ROW_TYPED
   } row_kind_type;

   typedef enum logic [1:0] {
      STYLE_TRACK,
      STYLE_EXTREME,
      STYLE_NOISE
   } burst_style_type;

   typedef struct {
      row_kind_type    kind;
      csr_index_type   index;
      logic [GAIN_W-1:0] wdata;
      req_payload_type sample;
      rsp_payload_type want;
   } stim_row_type;

   typedef struct {
      bit              typed;
      rsp_payload_type want;
   } sample_note_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_we;
   csr_index_type   csr_index;
   logic [GAIN_W-1:0] csr_wdata;

   longint gain_p;
   longint gain_i;
   longint gain_ff;
   longint integ_limit;
   longint integ_acc;
   longint out_raw;

   sample_note_type sample_notes[$];
   rsp_payload_type expected_cmds[$];
   stim_row_type    directed_rows[$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              quiet_cycles = 0;

   pitch_rate_pi_controller_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint limit_to(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic rsp_payload_type pitch_law_step(req_payload_type smp);
      longint unity;
      longint sp;
      longint err;
      longint scl;
      longint s2;
      longint incr;
      longint ff;
      longint prop;
      longint act;
      rsp_payload_type cmd;
      unity = longint'(1) <<< FRAC;
      if (smp.inputs_valid) begin
         sp = longint'($signed(smp.rate_setpoint));
         err = sp - longint'($signed(smp.measured_rate));
         scl = longint'(smp.airspeed_scaler);
         s2 = (scl * scl) >>> FRAC;
         if (!smp.lock_integ && gain_i != 0) begin
            incr = (err * longint'(smp.time_step)) >>> DT_FRAC;
            incr = (incr * s2) >>> FRAC;
            // The increment may not push further into actuator saturation.
            if ((out_raw < -unity && incr < 0) || (out_raw > unity && incr > 0))
               incr = 0;
            incr = (incr * gain_i) >>> FRAC;
            integ_acc = limit_to(integ_acc + incr, -integ_limit, integ_limit);
         end
         ff = (sp * scl * gain_ff) >>> (2 * FRAC);
         prop = (err * s2 * gain_p) >>> (2 * FRAC);
         out_raw = limit_to(ff + prop + integ_acc, RAW_LO, RAW_HI);
      end
      act = limit_to(out_raw, -unity, unity);
      cmd.actuator = act[ACT_W-1:0];
      cmd.saturated = (out_raw > unity) || (out_raw < -unity);
      return cmd;
   endfunction

   function automatic req_payload_type make_sample(logic [15:0] sp, logic [15:0] meas,
                                                   logic [13:0] scl, logic [15:0] dt,
                                                   logic lock, logic valid);
      req_payload_type smp;
      smp.rate_setpoint = sp;
      smp.measured_rate = meas;
      smp.airspeed_scaler = scl;
      smp.time_step = dt;
      smp.lock_integ = lock;
      smp.inputs_valid = valid;
      return smp;
   endfunction

   function automatic stim_row_type csr_row(csr_index_type idx, logic [GAIN_W-1:0] val);
      stim_row_type row;
      row = '{ROW_CSR, idx, val, '0, '0};
      return row;
   endfunction

   function automatic stim_row_type checked_row(logic [15:0] sp, logic [15:0] meas,
                                                logic [13:0] scl, logic [15:0] dt,
                                                logic lock, logic valid);
      stim_row_type row;
      row = '{ROW_CHECKED, CSR_GAIN_P, '0, make_sample(sp, meas, scl, dt, lock, valid), '0};
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic [15:0] sp, logic [15:0] meas,
                                              logic [13:0] scl, logic [15:0] dt,
                                              logic lock, logic valid,
                                              logic [ACT_W-1:0] act, logic sat);
      stim_row_type row;
      row = '{ROW_TYPED, CSR_GAIN_P, '0, make_sample(sp, meas, scl, dt, lock, valid),
              '{act, sat}};
      return row;
   endfunction

   function automatic logic [15:0] pick_extreme16();
      case ($urandom_range(4))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_sample(burst_style_type style, int center);
      req_payload_type smp;
      int sp;
      int meas;
      smp = req_payload_type'({$urandom, $urandom});
      smp.lock_integ = ($urandom_range(99) < 15);
      smp.inputs_valid = ($urandom_range(99) < 92);
      case (style)
         STYLE_TRACK: begin
            sp = center + int'($urandom_range(1024)) - 512;
            meas = sp + int'($urandom_range(4096)) - 2048;
            smp.rate_setpoint = sp[15:0];
            smp.measured_rate = meas[15:0];
            smp.airspeed_scaler = 14'($urandom_range(8192, 2048));
            smp.time_step = 16'($urandom_range(2048));
         end
         STYLE_EXTREME: begin
            smp.rate_setpoint = pick_extreme16();
            smp.measured_rate = pick_extreme16();
            smp.time_step = pick_extreme16();
            case ($urandom_range(2))
               0: smp.airspeed_scaler = 14'h3fff;
               1: smp.airspeed_scaler = 14'h0000;
               default: smp.airspeed_scaler = 14'($urandom);
            endcase
         end
         default: begin
            smp.inputs_valid = 1'($urandom_range(1));
            smp.lock_integ = 1'($urandom_range(1));
         end
      endcase
      return smp;
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sample_notes.size() != 0 || expected_cmds.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [GAIN_W-1:0] val);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GAIN_P: gain_p = longint'(val);
         CSR_GAIN_I: gain_i = longint'(val);
         CSR_GAIN_FF: gain_ff = longint'(val);
         CSR_INT_LIM: integ_limit = longint'(val);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                              logic [GAIN_W-1:0] ff, logic [GAIN_W-1:0] lim);
      write_register(CSR_GAIN_P, p);
      write_register(CSR_GAIN_I, i);
      write_register(CSR_GAIN_FF, ff);
      write_register(CSR_INT_LIM, lim);
   endtask

   task automatic send_sample(req_payload_type smp, bit typed, rsp_payload_type want);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      sample_notes.push_back('{typed, want});
      req_valid <= 1'b1;
      req_payload <= smp;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      sample_note_type note;
      rsp_payload_type predicted;
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = pitch_law_step(req_payload);
            if (sample_notes.size() == 0) begin
               $error("sample transfer with no sample sent");
               error_count++;
            end else begin
               note = sample_notes.pop_front();
               expected_cmds.push_back(note.typed ? note.want : predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               $error("command transfer with no command expected: actuator %0d saturated %0b",
                      $signed(rsp_payload.actuator), rsp_payload.saturated);
               error_count++;
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_payload.actuator !== want.actuator) begin
                  $error("actuator: expected %0d, got %0d",
                         $signed(want.actuator), $signed(rsp_payload.actuator));
                  error_count++;
               end
               if (rsp_payload.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b",
                         want.saturated, rsp_payload.saturated);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[pitch_rate_pi_controller_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int sent;
      int burst;
      int center;
      burst_style_type style;
      logic [GAIN_W-1:0] set_p;
      logic [GAIN_W-1:0] set_i;
      logic [GAIN_W-1:0] set_ff;
      logic [GAIN_W-1:0] set_lim;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_stall <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_GAIN_P;
      csr_wdata <= '0;
      gain_p = 0;
      gain_i = 0;
      gain_ff = 0;
      integ_limit = 0;
      integ_acc = 0;
      out_raw = 0;

      // With every gain at zero after reset, every command is zero.
      directed_rows.push_back(typed_row(16'h7fff, 16'h8000, 14'h3fff, 16'hffff, 1'b0, 1'b1,
                                        14'sd0, 1'b0));
      directed_rows.push_back(typed_row(16'h8000, 16'h7fff, 14'h0000, 16'h0000, 1'b1, 1'b1,
                                        14'sd0, 1'b0));
      directed_rows.push_back(typed_row(16'h7fff, 16'h8000, 14'h3fff, 16'hffff, 1'b0, 1'b0,
                                        14'sd0, 1'b0));
      directed_rows.push_back(csr_row(CSR_GAIN_P, 16'hffff));
      directed_rows.push_back(csr_row(CSR_GAIN_I, 16'hffff));
      directed_rows.push_back(csr_row(CSR_GAIN_FF, 16'hffff));
      directed_rows.push_back(csr_row(CSR_INT_LIM, 16'hffff));
      // Full gains and the largest error drive the output to positive saturation.
      directed_rows.push_back(typed_row(16'h7fff, 16'h8000, 14'h3fff, 16'hffff, 1'b0, 1'b1,
                                        14'sd4096, 1'b1));
      directed_rows.push_back(typed_row(16'h0000, 16'h0000, 14'h0000, 16'h0000, 1'b0, 1'b0,
                                        14'sd4096, 1'b1));
      directed_rows.push_back(checked_row(16'h0000, 16'h0000, 14'h1000, 16'h0800, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h8000, 16'h7fff, 14'h3fff, 16'hffff, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h8000, 16'h7fff, 14'h3fff, 16'hffff, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h0000, 16'h0000, 14'h1000, 16'h0000, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h1000, 16'h0000, 14'h1000, 16'h0800, 1'b1, 1'b1));
      directed_rows.push_back(csr_row(CSR_INT_LIM, 16'h0100));
      directed_rows.push_back(checked_row(16'h1000, 16'h0000, 14'h1000, 16'h0800, 1'b1, 1'b1));
      directed_rows.push_back(checked_row(16'h0800, 16'h0000, 14'h1000, 16'h0800, 1'b0, 1'b1));
      directed_rows.push_back(csr_row(CSR_GAIN_I, 16'h0000));
      directed_rows.push_back(checked_row(16'h0800, 16'h0000, 14'h1000, 16'h0800, 1'b0, 1'b1));
      directed_rows.push_back(csr_row(CSR_GAIN_P, 16'h1000));
      directed_rows.push_back(csr_row(CSR_GAIN_I, 16'h1000));
      directed_rows.push_back(csr_row(CSR_GAIN_FF, 16'h1000));
      directed_rows.push_back(csr_row(CSR_INT_LIM, 16'h2000));
      directed_rows.push_back(checked_row(16'h1000, 16'h0800, 14'h1000, 16'h0100, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'hffff, 16'h0000, 14'h1000, 16'h0100, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h0000, 16'h0001, 14'h0001, 16'h0001, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h1000, 16'h1000, 14'h0000, 16'hffff, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h7000, 16'h9000, 14'h2000, 16'h4000, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h0100, 16'h0000, 14'h1000, 16'h0100, 1'b0, 1'b1));
      directed_rows.push_back(checked_row(16'h0000, 16'h0000, 14'h1000, 16'h0000, 1'b0, 1'b0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_register(directed_rows[r].index, directed_rows[r].wdata);
         else
            send_sample(directed_rows[r].sample, directed_rows[r].kind == ROW_TYPED,
                        directed_rows[r].want);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 53; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 53; end
            default: begin send_idle_pct = 12; stall_pct <= 12; end
         endcase
         if (phase < 6) begin
            set_p = GAIN_SETS[phase][0];
            set_i = GAIN_SETS[phase][1];
            set_ff = GAIN_SETS[phase][2];
            set_lim = GAIN_SETS[phase][3];
         end else begin
            set_p = 16'($urandom_range(16'h2000));
            set_i = 16'($urandom);
            set_ff = 16'($urandom_range(16'h2000));
            set_lim = 16'($urandom);
         end
         write_gains(set_p, set_i, set_ff, set_lim);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            case ($urandom_range(99) / 20)
               0: style = STYLE_NOISE;
               1: style = ($urandom_range(3) == 0) ? STYLE_EXTREME : STYLE_TRACK;
               default: style = STYLE_TRACK;
            endcase
            center = int'($urandom_range(16384)) - 8192;
            burst = $urandom_range(30, 1);
            repeat (burst) begin
               send_sample(random_sample(style, center), 1'b0, '0);
               sent++;
            end
         end
         wait_idle();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[pitch_rate_pi_controller_top] OK");
      else
         $display("[pitch_rate_pi_controller_top] ERROR");
      $finish;
   end

endmodule
